### rtl/kdlp_pkg.sv
// Shared types and constants for the key debounce and long-press scanner.
package kdlp_pkg;

    localparam int NUM_KEYS  = 8;
    localparam int PIN_W     = 8;
    localparam int CNT_W     = 16;
    localparam int IDX_W     = 3;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 16;
    localparam int ACT_W     = 4;

    localparam logic [CFG_ADDR_W-1:0] REG_LONG_PRESS  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_SETTLE      = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ACTIVE_KEYS = 2'd2;

    localparam logic [1:0] ST_UP      = 2'd0;
    localparam logic [1:0] ST_SETTLE  = 2'd1;
    localparam logic [1:0] ST_PRESSED = 2'd2;
    localparam logic [1:0] ST_LONG    = 2'd3;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef struct packed {
        logic             done;
        logic             found;
        logic [1:0]       status;
        logic [CNT_W-1:0] count;
    } cell_rpt_t;

    typedef struct packed {
        logic [CNT_W-1:0] long_press;
        logic [CNT_W-1:0] settle;
    } cell_cfg_t;

endpackage

### rtl/kdlp_cell.sv
// One key cell: holds one key's state machine and counters, passes the scan token on.
module kdlp_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  kdlp_pkg::cell_cfg_t cfg,
    input  logic                token_in,
    input  logic                enable,
    input  logic                level,
    output logic                token_out,
    output kdlp_pkg::cell_rpt_t rpt
);

    logic [1:0]                 state_reg, state_next;
    logic [kdlp_pkg::CNT_W-1:0] settle_reg, settle_next;
    logic [kdlp_pkg::CNT_W-1:0] press_reg, press_next;
    logic                       token_reg, token_next;
    logic [kdlp_pkg::CNT_W-1:0] press_inc;

    assign press_inc = (press_reg == kdlp_pkg::CNT_MAX) ? press_reg
                                                        : press_reg + 1'b1;

    always_comb begin
        state_next  = state_reg;
        settle_next = settle_reg;
        press_next  = press_reg;
        if (token_in && enable) begin
            case (state_reg)
                kdlp_pkg::ST_UP: begin
                    if (level) begin
                        state_next = kdlp_pkg::ST_SETTLE;
                    end
                end
                kdlp_pkg::ST_SETTLE: begin
                    if (settle_reg < cfg.settle && settle_reg != kdlp_pkg::CNT_MAX) begin
                        settle_next = settle_reg + 1'b1;
                    end else begin
                        settle_next = '0;
                        if (level) begin
                            state_next = kdlp_pkg::ST_PRESSED;
                            press_next = press_inc;
                        end else begin
                            state_next = kdlp_pkg::ST_UP;
                            press_next = '0;
                        end
                    end
                end
                kdlp_pkg::ST_PRESSED: begin
                    if (level) begin
                        press_next = press_inc;
                        if (press_inc > cfg.long_press) begin
                            state_next = kdlp_pkg::ST_LONG;
                        end
                    end else begin
                        state_next = kdlp_pkg::ST_UP;
                        press_next = '0;
                    end
                end
                default: begin
                    if (level) begin
                        press_next = press_inc;
                    end else begin
                        state_next = kdlp_pkg::ST_UP;
                        press_next = '0;
                    end
                end
            endcase
        end
    end

    assign token_next = token_in && enable && (state_next == kdlp_pkg::ST_UP);

    always_comb begin
        rpt.done   = token_in && (!enable || state_next != kdlp_pkg::ST_UP);
        rpt.found  = token_in && enable && (state_next != kdlp_pkg::ST_UP);
        rpt.status = state_next;
        rpt.count  = press_next;
    end

    assign token_out = token_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= kdlp_pkg::ST_UP;
            settle_reg <= '0;
            press_reg  <= '0;
            token_reg  <= 1'b0;
        end else begin
            state_reg  <= state_next;
            settle_reg <= settle_next;
            press_reg  <= press_next;
            token_reg  <= token_next;
        end
    end

endmodule

### rtl/key_debounce_long_press_scanner.sv
// Top level: key debounce and long-press scanner built from a row of key cells.
//
//  channel   direction  tdata / fields (lowest bit first)
//  s_        in         pin_levels[7:0]
//  m_        out        found[0], key_index[3:1], status[5:4], press_ticks[21:6]
//  cfg_      in         write-only register port, index 0..2
//
//  A scan token walks the cells one key per cycle and stops at the first key that
//  is not up or not active; the result is then registered into the m_ output register.
//  The next tick is taken the cycle after the result has been transferred.
//  Reset clears every key to up with zero counters; registers return to defaults.
//  A stalled result holds in the output register until m_tready.
module key_debounce_long_press_scanner (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [7:0]                        s_tdata,   // pin_levels[7:0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // found[0], key_index[3:1], status[5:4], press_ticks[21:6], zero[23:22]
    output logic [23:0]                       m_tdata,
    input  logic                              cfg_wr_en,
    input  logic [kdlp_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [kdlp_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

    logic [kdlp_pkg::CNT_W-1:0] long_press_reg;
    logic [kdlp_pkg::CNT_W-1:0] settle_reg;
    logic [kdlp_pkg::ACT_W-1:0] active_reg;
    logic [kdlp_pkg::PIN_W-1:0] pins_reg;
    logic                       busy_reg, busy_next;
    logic                       start_reg;
    logic                       out_valid_reg, out_valid_next;
    logic [23:0]                out_data_reg, out_data_next;

    kdlp_pkg::cell_cfg_t        cell_cfg;
    kdlp_pkg::cell_rpt_t        rpt [kdlp_pkg::NUM_KEYS];
    logic [kdlp_pkg::NUM_KEYS:0] token;

    logic                       done_any;
    logic                       found_any;
    logic [kdlp_pkg::IDX_W-1:0] idx_sel;
    logic [1:0]                 status_sel;
    logic [kdlp_pkg::CNT_W-1:0] count_sel;

    assign cell_cfg.long_press = long_press_reg;
    assign cell_cfg.settle     = settle_reg;
    assign token[0]            = start_reg;

    genvar k;
    generate
        for (k = 0; k < kdlp_pkg::NUM_KEYS; k++) begin : g_cell
            logic lvl;
            logic en;
            if (k < kdlp_pkg::PIN_W) begin : g_pin
                assign lvl = pins_reg[k];
            end else begin : g_nopin
                assign lvl = 1'b0;
            end
            assign en = ({1'b0, active_reg} > (kdlp_pkg::ACT_W+1)'(k));
            kdlp_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .cfg       (cell_cfg),
                .token_in  (token[k]),
                .enable    (en),
                .level     (lvl),
                .token_out (token[k+1]),
                .rpt       (rpt[k])
            );
        end
    endgenerate

    always_comb begin
        done_any   = token[kdlp_pkg::NUM_KEYS];
        found_any  = 1'b0;
        idx_sel    = '0;
        status_sel = '0;
        count_sel  = '0;
        for (int i = 0; i < kdlp_pkg::NUM_KEYS; i++) begin
            done_any = done_any | rpt[i].done;
            if (rpt[i].found) begin
                found_any  = 1'b1;
                idx_sel    = idx_sel | kdlp_pkg::IDX_W'(i);
                status_sel = status_sel | rpt[i].status;
                count_sel  = count_sel | rpt[i].count;
            end
        end
    end

    assign s_tready = !busy_reg && !out_valid_reg;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    always_comb begin
        busy_next      = busy_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end
        if (s_tvalid && s_tready) begin
            busy_next = 1'b1;
        end
        if (done_any) begin
            busy_next      = 1'b0;
            out_valid_next = 1'b1;
            out_data_next  = {2'b00, count_sel, status_sel, idx_sel, found_any};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            long_press_reg <= '0;
            settle_reg     <= '0;
            active_reg     <= kdlp_pkg::ACT_W'(8);
            busy_reg       <= 1'b0;
            start_reg      <= 1'b0;
            out_valid_reg  <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_addr)
                    kdlp_pkg::REG_LONG_PRESS:  long_press_reg <= cfg_wdata;
                    kdlp_pkg::REG_SETTLE:      settle_reg     <= cfg_wdata;
                    kdlp_pkg::REG_ACTIVE_KEYS: active_reg     <= cfg_wdata[kdlp_pkg::ACT_W-1:0];
                    default: ;
                endcase
            end
            busy_reg      <= busy_next;
            start_reg     <= s_tvalid && s_tready;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            pins_reg <= s_tdata;
        end
        out_data_reg <= out_data_next;
    end

endmodule

### rtl/kdlp_checker.sv
// Port checker for the key debounce and long-press scanner, bound to the top level.
module kdlp_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result dropped or changed while stalled");

    a_none_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[23:1] == 23'd0)
        else $error("empty scan result carries nonzero fields");

    a_found_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] |-> m_tdata[5:4] != kdlp_pkg::ST_UP)
        else $error("found key reported as up");

    a_settle_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[0] && m_tdata[5:4] == kdlp_pkg::ST_SETTLE
            |-> m_tdata[21:6] == 16'd0)
        else $error("settling key reports press ticks");

    a_one_tick: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second tick taken before result");

endmodule

bind key_debounce_long_press_scanner kdlp_checker u_kdlp_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
